// ----- rtl/dvr_pkg.sv -----
// Shared types and constants for the distance-vector route solver.
package dvr_pkg;

  localparam int NODE_W         = 3;
  localparam int COST_W         = 14;
  localparam int CFG_W          = 4;
  localparam int NODE_LIMIT_DEF = 8;

  localparam logic [COST_W-1:0] NO_LINK        = 14'd9999;
  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 4'd8;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [COST_W-1:0] link_cost;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] route_src;
    logic [NODE_W-1:0] route_dst;
    logic [NODE_W-1:0] next_hop;
    logic [COST_W-1:0] path_cost;
    logic              last_route;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_RLX_CUR,
    ST_RLX_K,
    ST_RLX_LAST,
    ST_EM_RD,
    ST_EM_CAP
  } state_t;

  typedef struct packed {
    logic link_we;
    logic dist_we;
    logic hop_we;
  } tbl_we_t;

endpackage

// ----- rtl/dvr_tables.sv -----
// Link matrix, distance table and next-hop table memories (registered read).
module dvr_tables #(
  parameter int  NODE_LIMIT = dvr_pkg::NODE_LIMIT_DEF,
  localparam int IDX_W      = $clog2(NODE_LIMIT),
  localparam int DEPTH      = NODE_LIMIT * NODE_LIMIT,
  localparam int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  dvr_pkg::tbl_we_t           we,
  input  logic [ADDR_W-1:0]          link_waddr,
  input  logic [dvr_pkg::COST_W-1:0] link_wdata,
  input  logic [ADDR_W-1:0]          link_raddr,
  output logic [dvr_pkg::COST_W-1:0] link_rdata,
  input  logic [ADDR_W-1:0]          dist_waddr,
  input  logic [dvr_pkg::COST_W-1:0] dist_wdata,
  input  logic [IDX_W-1:0]           hop_wdata,
  input  logic [ADDR_W-1:0]          dist_raddr,
  output logic [dvr_pkg::COST_W-1:0] dist_rdata,
  output logic [IDX_W-1:0]           hop_rdata
);

  logic [dvr_pkg::COST_W-1:0] link_mem [DEPTH];
  logic [dvr_pkg::COST_W-1:0] dist_mem [DEPTH];
  logic [IDX_W-1:0]           hop_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rdata <= dist_mem[dist_raddr];
  end

  // hop table shares the distance table's addresses
  always_ff @(posedge clk) begin
    if (we.hop_we) begin
      hop_mem[dist_waddr] <= hop_wdata;
    end
    hop_rdata <= hop_mem[dist_raddr];
  end

endmodule

// ----- rtl/dvr_seq.sv -----
// Sequencer: matrix load, table init, relaxation sweeps and route output.
module dvr_seq #(
  parameter int  NODE_LIMIT = dvr_pkg::NODE_LIMIT_DEF,
  localparam int IDX_W      = $clog2(NODE_LIMIT),
  localparam int DEPTH      = NODE_LIMIT * NODE_LIMIT,
  localparam int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IDX_W-1:0]           nm1,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dvr_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dvr_pkg::out_item_t         out_item,
  output dvr_pkg::tbl_we_t           we,
  output logic [ADDR_W-1:0]          link_waddr,
  output logic [dvr_pkg::COST_W-1:0] link_wdata,
  output logic [ADDR_W-1:0]          link_raddr,
  input  logic [dvr_pkg::COST_W-1:0] link_rdata,
  output logic [ADDR_W-1:0]          dist_waddr,
  output logic [dvr_pkg::COST_W-1:0] dist_wdata,
  output logic [IDX_W-1:0]           hop_wdata,
  output logic [ADDR_W-1:0]          dist_raddr,
  input  logic [dvr_pkg::COST_W-1:0] dist_rdata,
  input  logic [IDX_W-1:0]           hop_rdata
);

  localparam int COST_W = dvr_pkg::COST_W;
  localparam int NODE_W = dvr_pkg::NODE_W;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    tbl_addr = ADDR_W'(r * NODE_LIMIT + c);
  endfunction

  dvr_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, kd_r, kd_nxt;
  logic [COST_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]   hop_r, hop_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               pair_chg_r, pair_chg_nxt;
  logic               chg_r, chg_nxt;
  dvr_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               at_i_end, at_j_end, at_k_end;
  logic [COST_W-1:0]  other;
  logic [COST_W:0]    via;
  logic               better;
  logic [COST_W-1:0]  cur_upd;
  logic [IDX_W-1:0]   hop_upd;
  logic               any_chg;
  logic [COST_W-1:0]  cost_sat;
  logic               in_range;

  assign at_i_end = (i_r == nm1);
  assign at_j_end = (j_r == nm1);
  assign at_k_end = (k_r == nm1);

  // relax compare; own entry is forwarded from cur_r (memory copy may be stale)
  assign other   = (kd_r == i_r) ? cur_r : dist_rdata;
  assign via     = {1'b0, link_rdata} + {1'b0, other};
  assign better  = (via < {1'b0, cur_r});
  assign cur_upd = better ? via[COST_W-1:0] : cur_r;
  assign hop_upd = better ? kd_r : hop_r;
  assign any_chg = chg_r | pair_chg_r | better;

  // load path
  always_comb begin
    cost_sat = (in_item.link_cost > dvr_pkg::NO_LINK) ? dvr_pkg::NO_LINK : in_item.link_cost;
    if (in_item.src_node == in_item.dst_node) begin
      cost_sat = '0;
    end
  end
  assign in_range   = (in_item.src_node <= NODE_W'(nm1)) &&
                      (in_item.dst_node <= NODE_W'(nm1));
  assign link_waddr = tbl_addr(in_item.src_node[IDX_W-1:0], in_item.dst_node[IDX_W-1:0]);
  assign link_wdata = cost_sat;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    kd_nxt        = kd_r;
    cur_nxt       = cur_r;
    hop_nxt       = hop_r;
    cmp_vld_nxt   = cmp_vld_r;
    pair_chg_nxt  = pair_chg_r;
    chg_nxt       = chg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    we            = '0;
    link_raddr    = tbl_addr(i_r, k_r);
    dist_raddr    = tbl_addr(i_r, j_r);
    dist_waddr    = tbl_addr(i_r, j_r);
    dist_wdata    = cur_upd;
    hop_wdata     = hop_upd;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dvr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          we.link_we = in_range;
          if (in_item.last) begin
            i_nxt     = '0;
            j_nxt     = '0;
            k_nxt     = '0;
            state_nxt = dvr_pkg::ST_INIT_RD;
          end
        end
      end
      dvr_pkg::ST_INIT_RD: begin
        link_raddr = tbl_addr(i_r, j_r);
        state_nxt  = dvr_pkg::ST_INIT_WR;
      end
      dvr_pkg::ST_INIT_WR: begin
        // dist = link, next hop = destination
        link_raddr = tbl_addr(i_r, j_r);
        we.dist_we = 1'b1;
        we.hop_we  = 1'b1;
        dist_wdata = link_rdata;
        hop_wdata  = j_r;
        state_nxt  = dvr_pkg::ST_INIT_RD;
        if (at_j_end) begin
          j_nxt = '0;
          if (at_i_end) begin
            i_nxt     = '0;
            chg_nxt   = 1'b0;
            state_nxt = dvr_pkg::ST_RLX_CUR;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      dvr_pkg::ST_RLX_CUR: begin
        k_nxt        = '0;
        cmp_vld_nxt  = 1'b0;
        pair_chg_nxt = 1'b0;
        state_nxt    = dvr_pkg::ST_RLX_K;
      end
      dvr_pkg::ST_RLX_K: begin
        link_raddr  = tbl_addr(i_r, k_r);
        dist_raddr  = tbl_addr(k_r, j_r);
        kd_nxt      = k_r;
        cmp_vld_nxt = 1'b1;
        if (!cmp_vld_r) begin
          cur_nxt = dist_rdata;
        end else begin
          cur_nxt = cur_upd;
          hop_nxt = hop_upd;
          if (better) begin
            pair_chg_nxt = 1'b1;
          end
        end
        if (at_k_end) begin
          state_nxt = dvr_pkg::ST_RLX_LAST;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      dvr_pkg::ST_RLX_LAST: begin
        // final compare, write back the pair
        we.dist_we = 1'b1;
        we.hop_we  = pair_chg_r | better;
        chg_nxt    = any_chg;
        state_nxt  = dvr_pkg::ST_RLX_CUR;
        if (at_j_end) begin
          j_nxt = '0;
          if (at_i_end) begin
            i_nxt = '0;
            if (any_chg) begin
              chg_nxt = 1'b0;
            end else begin
              state_nxt = dvr_pkg::ST_EM_RD;
            end
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      dvr_pkg::ST_EM_RD: begin
        state_nxt = dvr_pkg::ST_EM_CAP;
      end
      dvr_pkg::ST_EM_CAP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.route_src  = NODE_W'(i_r);
          out_nxt.route_dst  = NODE_W'(j_r);
          out_nxt.next_hop   = NODE_W'(hop_rdata);
          out_nxt.path_cost  = dist_rdata;
          out_nxt.last_route = at_i_end && at_j_end;
          out_valid_nxt      = 1'b1;
          state_nxt          = dvr_pkg::ST_EM_RD;
          if (at_j_end) begin
            j_nxt = '0;
            if (at_i_end) begin
              i_nxt     = '0;
              state_nxt = dvr_pkg::ST_IDLE;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = dvr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      chg_r       <= 1'b0;
      cmp_vld_r   <= 1'b0;
      pair_chg_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      chg_r       <= chg_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      pair_chg_r  <= pair_chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kd_r  <= kd_nxt;
    cur_r <= cur_nxt;
    hop_r <= hop_nxt;
    out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dvr_pkg::ST_IDLE) |-> (i_r <= nm1) && (j_r <= nm1) && (k_r <= nm1))
    else $error("loop index beyond node count");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dvr_pkg::ST_EM_CAP))
    else $error("route presented outside emit phase");

  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == dvr_pkg::ST_RLX_LAST) && (state_r == dvr_pkg::ST_EM_RD))
      |-> (i_r == '0) && (j_r == '0))
    else $error("emit did not start at first route");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.last) |=> (state_r == dvr_pkg::ST_INIT_RD))
    else $error("last item did not start table init");
`endif

endmodule

// ----- rtl/distance_vector_route_solver.sv -----
// Top level: distance-vector route solver (config register, sequencer, tables).
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+--------------------
//  in_     | input     | dvr_pkg::in_item_t   | in_valid / in_ready
//  out_    | output    | dvr_pkg::out_item_t  | out_valid / out_ready
//  cfg_    | input     | node_count, 4 bits   | cfg_valid / cfg_ready
//
// Sequence: each accepted in-range item writes one matrix entry. A last item then
//   starts table init (link read, then dist/hop write, per entry), then relaxation
//   sweeps (one via-node per cycle on the single dist read port, plus a read and
//   a write-back per pair), repeated until a sweep changes nothing, then route
//   output (dist/hop read, then capture, per route) while out_ready stays high.
// Reset: rst_n is synchronous, active low; node_count returns to 8. Table memories
//   are not cleared; init writes dist/hop before they are read, loads write links.
// Stalls: out_ready low holds the output register and the emit sequence;
//   in_ready is high only while idle, even with the last route still waiting.
module distance_vector_route_solver #(
  parameter int  MAX_NODE_COUNT = dvr_pkg::NODE_LIMIT_DEF,
  localparam int IDX_W          = $clog2(MAX_NODE_COUNT),
  localparam int DEPTH          = MAX_NODE_COUNT * MAX_NODE_COUNT,
  localparam int ADDR_W         = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dvr_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dvr_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dvr_pkg::CFG_W-1:0] cfg_node_count
);

  logic [dvr_pkg::CFG_W-1:0]  node_count_r;
  logic [IDX_W-1:0]           nm1;   // nodes in use minus one

  dvr_pkg::tbl_we_t           we;
  logic [ADDR_W-1:0]          link_waddr, link_raddr, dist_waddr, dist_raddr;
  logic [dvr_pkg::COST_W-1:0] link_wdata, link_rdata, dist_wdata, dist_rdata;
  logic [IDX_W-1:0]           hop_wdata, hop_rdata;

  // config must only be written while idle (the block does not enforce this), so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= dvr_pkg::NODE_COUNT_RST;
    end else if (cfg_valid) begin
      node_count_r <= cfg_node_count;
    end
  end

  // zero acts as one node, anything above the max saturates
  always_comb begin
    if (node_count_r == '0) begin
      nm1 = '0;
    end else if (node_count_r > dvr_pkg::CFG_W'(MAX_NODE_COUNT)) begin
      nm1 = IDX_W'(MAX_NODE_COUNT - 1);
    end else begin
      nm1 = IDX_W'(node_count_r - 1'b1);
    end
  end

  dvr_seq #(
    .NODE_LIMIT (MAX_NODE_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .nm1        (nm1),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .we         (we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .dist_waddr (dist_waddr),
    .dist_wdata (dist_wdata),
    .hop_wdata  (hop_wdata),
    .dist_raddr (dist_raddr),
    .dist_rdata (dist_rdata),
    .hop_rdata  (hop_rdata)
  );

  dvr_tables #(
    .NODE_LIMIT (MAX_NODE_COUNT)
  ) u_tables (
    .clk        (clk),
    .we         (we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .dist_waddr (dist_waddr),
    .dist_wdata (dist_wdata),
    .hop_wdata  (hop_wdata),
    .dist_raddr (dist_raddr),
    .dist_rdata (dist_rdata),
    .hop_rdata  (hop_rdata)
  );

endmodule

// ----- dv/distance_vector_route_solver_tb.sv -----
// Self-checking testbench for the distance-vector route solver: random matrices, route checks.
module distance_vector_route_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX        = dvr_pkg::NODE_LIMIT_DEF;
  localparam int COST_W      = dvr_pkg::COST_W;
  localparam int NODE_W      = dvr_pkg::NODE_W;
  localparam int CFG_W       = dvr_pkg::CFG_W;
  localparam int SLOTS       = NMAX * NMAX;
  localparam int STUCK_LIMIT = 60000;  // watchdog limit, sized for the slowest 8-node solve plus stalls
  localparam int ITEM_TARGET = 370;
  localparam int QUIET_AFTER = 320;    // no idling on either side past this many items

  // Predicts the route table for each last item and checks emitted routes in order.
  class route_scoreboard;
    logic [COST_W-1:0]  link_mem [SLOTS];
    logic [CFG_W-1:0]   node_count_reg;
    dvr_pkg::out_item_t route_q [$];
    int                 errors;

    function new();
      node_count_reg = dvr_pkg::NODE_COUNT_RST;
      errors = 0;
      foreach (link_mem[s]) link_mem[s] = '0;
    endfunction

    function void set_node_count(logic [CFG_W-1:0] v);
      node_count_reg = v;
    endfunction

    function int pending();
      return route_q.size();
    endfunction

    // Store the entry, and on a last item run the relaxation to a fixed point.
    function void note_input(dvr_pkg::in_item_t it);
      logic [COST_W-1:0]  dist_v [SLOTS];
      logic [NODE_W-1:0]  hop_v  [SLOTS];
      logic [COST_W-1:0]  cost;
      int                 n;
      int                 via;
      bit                 changed;
      dvr_pkg::out_item_t r;
      n = node_count_reg;
      if (n == 0) n = 1;
      if (n > NMAX) n = NMAX;
      cost = (it.link_cost > dvr_pkg::NO_LINK) ? dvr_pkg::NO_LINK : it.link_cost;
      if (it.src_node == it.dst_node) cost = '0;
      if (it.src_node < n && it.dst_node < n)
        link_mem[it.src_node * NMAX + it.dst_node] = cost;
      if (!it.last) return;

      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          dist_v[i * NMAX + j] = link_mem[i * NMAX + j];
          hop_v[i * NMAX + j]  = NODE_W'(j);
        end
      end
      // In-place sweeps: an update is visible to later via-nodes in the same sweep.
      do begin
        changed = 1'b0;
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            for (int k = 0; k < n; k++) begin
              via = int'(link_mem[i * NMAX + k]) + int'(dist_v[k * NMAX + j]);
              if (via < int'(dist_v[i * NMAX + j])) begin
                dist_v[i * NMAX + j] = COST_W'(via);
                hop_v[i * NMAX + j]  = NODE_W'(k);
                changed = 1'b1;
              end
            end
          end
        end
      end while (changed);

      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          r.route_src  = NODE_W'(i);
          r.route_dst  = NODE_W'(j);
          r.next_hop   = hop_v[i * NMAX + j];
          r.path_cost  = dist_v[i * NMAX + j];
          r.last_route = (i == n - 1) && (j == n - 1);
          route_q.push_back(r);
        end
      end
    endfunction

    function void cmp_field(string fname, logic [COST_W-1:0] want, logic [COST_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(dvr_pkg::out_item_t got);
      dvr_pkg::out_item_t want;
      if (route_q.size() == 0) begin
        $display("%0t ns: unexpected route, expected none, actual src=%0d dst=%0d cost=%0d",
                 $time, got.route_src, got.route_dst, got.path_cost);
        errors++;
        return;
      end
      want = route_q.pop_front();
      cmp_field("route_src",  COST_W'(want.route_src),  COST_W'(got.route_src));
      cmp_field("route_dst",  COST_W'(want.route_dst),  COST_W'(got.route_dst));
      cmp_field("next_hop",   COST_W'(want.next_hop),   COST_W'(got.next_hop));
      cmp_field("path_cost",  want.path_cost,           got.path_cost);
      cmp_field("last_route", COST_W'(want.last_route), COST_W'(got.last_route));
    endfunction
  endclass

  // DUT-facing signals; every input has a known value from time zero.
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  dvr_pkg::in_item_t  in_item        = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  dvr_pkg::out_item_t out_item;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_node_count = '0;

  route_scoreboard sb;

  // Stimulus bookkeeping
  int  cur_n         = NMAX;   // effective node count the block is using
  bit  written [SLOTS];        // matrix entries stored since reset
  int  load_items    = 0;      // in-range items sent (ignored ones don't count)
  bit  quiet         = 1'b0;   // tail of the run: no idling at all
  bit  in_gaps_on    = 1'b0;
  bit  out_stalls_on = 1'b0;
  int  stuck_cycles  = 0;

  distance_vector_route_solver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: every accepted item goes to the predictor, every accepted route to the checker.
  // Sampled right at the edge, so the values seen are the ones the handshake used.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // Watchdog: a run that stops moving on all three channels is a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("distance_vector_route_solver_tb NOT OK");
        $finish;
      end
    end
  end

  // Result-side backpressure: random low bursts, long high stretches.
  initial begin
    forever begin
      @(posedge clk);
      if (out_stalls_on && !quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic dvr_pkg::in_item_t mk_item(int s, int d, int c, bit fin);
    dvr_pkg::in_item_t it;
    it.src_node  = NODE_W'(s);
    it.dst_node  = NODE_W'(d);
    it.link_cost = COST_W'(c);
    it.last      = fin;
    return it;
  endfunction

  // Mostly sparse graphs with cheap links, so multi-hop routes show up.
  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0, 1, 2: return dvr_pkg::NO_LINK;
      3:       return COST_W'($urandom_range(10000, 16383));
      4:       return COST_W'($urandom_range(0, 16383));
      5:       return '0;
      default: return COST_W'($urandom_range(1, 40));
    endcase
  endfunction

  // Half the time an item off the matrix when there is room for one, else a rewrite of some entry.
  function automatic dvr_pkg::in_item_t noise_item(int n, bit fin);
    dvr_pkg::in_item_t it;
    int                s;
    int                d;
    if (n < NMAX && $urandom_range(0, 1) == 1) begin
      s = $urandom_range(0, NMAX - 1);
      d = $urandom_range(n, NMAX - 1);
      it = ($urandom_range(0, 1) == 1) ? mk_item(d, s, 0, fin) : mk_item(s, d, 0, fin);
    end else begin
      it = mk_item($urandom_range(0, n - 1), $urandom_range(0, n - 1), 0, fin);
    end
    it.link_cost = COST_W'($urandom_range(0, 16383));
    return it;
  endfunction

  // Send one item. Valid stays high between back-to-back items and only drops for a gap,
  // so it is never lowered and raised in the same step.
  task automatic push_item(dvr_pkg::in_item_t it);
    if (in_gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.src_node < cur_n && it.dst_node < cur_n) begin
      written[it.src_node * NMAX + it.dst_node] = 1'b1;
      load_items++;
    end
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] v);
    cfg_valid      <= 1'b1;
    cfg_node_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_node_count(v);
    cur_n = (v == 0) ? 1 : ((v > NMAX) ? NMAX : int'(v));
  endtask

  // Wait until every predicted route has come out, then let the block settle.
  // The first edge makes sure the monitor has seen the item accepted just now.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One well-formed matrix load ending in a last item: a full load in random order, or
  // a short partial update once the whole matrix is known to be written. Noise items
  // are mixed in, and sometimes the last flag rides on a separate noise item.
  task automatic load_matrix(int n);
    int                order [SLOTS];
    int                cnt;
    int                r;
    int                tmp;
    bit                all_done;
    bit                trailer;
    dvr_pkg::in_item_t it;
    all_done = 1'b1;
    for (int s = 0; s < n * n; s++)
      if (!written[(s / n) * NMAX + (s % n)]) all_done = 1'b0;
    if (all_done && $urandom_range(0, 3) == 0) begin
      cnt = $urandom_range(1, 4);
      for (int t = 0; t < cnt; t++)
        order[t] = $urandom_range(0, n - 1) * NMAX + $urandom_range(0, n - 1);
    end else begin
      cnt = n * n;
      for (int t = 0; t < cnt; t++) order[t] = (t / n) * NMAX + (t % n);
      for (int t = cnt - 1; t > 0; t--) begin
        r = $urandom_range(0, t);
        tmp = order[t];
        order[t] = order[r];
        order[r] = tmp;
      end
    end
    trailer = ($urandom_range(0, 4) == 0);
    for (int t = 0; t < cnt; t++) begin
      if ($urandom_range(0, 7) == 0) push_item(noise_item(n, 1'b0));
      it = mk_item(order[t] / NMAX, order[t] % NMAX, 0,
                   (t == cnt - 1) && !trailer);
      it.link_cost = pick_cost();
      push_item(it);
    end
    if (trailer) push_item(noise_item(n, 1'b1));
  endtask

  initial begin
    logic [CFG_W-1:0] v;
    sb = new();
    foreach (written[s]) written[s] = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: three nodes with every cost corner, then the degenerate sizes.
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    write_node_count(CFG_W'(3));
    push_item(mk_item(0, 0, 16383, 1'b0));  // diagonal with a cost: stored as zero
    push_item(mk_item(0, 1, 9999, 1'b0));   // no link
    push_item(mk_item(0, 2, 1, 1'b0));
    push_item(mk_item(1, 0, 10000, 1'b0));  // above no-link, saturates
    push_item(mk_item(1, 1, 0, 1'b0));
    push_item(mk_item(1, 2, 0, 1'b0));      // zero-cost link
    push_item(mk_item(2, 0, 5, 1'b0));
    push_item(mk_item(2, 1, 2, 1'b0));
    push_item(mk_item(2, 2, 7, 1'b0));
    push_item(mk_item(7, 7, 3, 1'b0));      // off the matrix: dropped
    push_item(mk_item(1, 5, 4, 1'b0));      // column off the matrix
    push_item(mk_item(6, 2, 1, 1'b1));      // off the matrix, but still starts the solve
    push_item(mk_item(2, 1, 16383, 1'b1));  // cost change re-solved right away
    drain();
    write_node_count(CFG_W'(1));            // single node
    push_item(mk_item(0, 0, 55, 1'b1));
    push_item(mk_item(3, 4, 9, 1'b1));
    drain();
    write_node_count(CFG_W'(0));            // zero treated as one node
    push_item(mk_item(0, 0, 123, 1'b1));
    drain();

    // Random phases: mostly small graphs, a few at full size, including oversized counts
    // that saturate. Several matrices per phase go back to back without a drain.
    while (load_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: v = CFG_W'($urandom_range(2, 4));
        6:                v = CFG_W'($urandom_range(0, 1));
        7:                v = CFG_W'(NMAX);
        8:                v = CFG_W'($urandom_range(NMAX + 1, 15));
        default:          v = CFG_W'($urandom_range(5, 7));
      endcase
      in_gaps_on    = ($urandom_range(0, 2) != 0);
      out_stalls_on = ($urandom_range(0, 2) != 0);
      write_node_count(v);
      repeat ($urandom_range(2, 4)) begin
        quiet = (load_items >= QUIET_AFTER);
        if (load_items < ITEM_TARGET) load_matrix(cur_n);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("distance_vector_route_solver_tb OK");
    end else begin
      $display("distance_vector_route_solver_tb NOT OK");
    end
    $finish;
  end

endmodule
